### rtl/vmid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vmid_pkg;

    localparam int unsigned NUM_PARAMS = 3;
    localparam int unsigned WIN_BYTES  = 14;
    localparam int unsigned WIN_BITS   = WIN_BYTES * 8;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_REG  = 2'd1;
    localparam logic [1:0] KIND_DIR  = 2'd2;
    localparam logic [1:0] KIND_IND  = 2'd3;

    localparam logic [7:0] OP_MIN   = 8'd1;
    localparam logic [7:0] OP_MAX   = 8'd16;
    localparam logic [7:0] OP_LIVE  = 8'd1;
    localparam logic [7:0] OP_ZJMP  = 8'd9;
    localparam logic [7:0] OP_LDI   = 8'd10;
    localparam logic [7:0] OP_STI   = 8'd11;
    localparam logic [7:0] OP_FORK  = 8'd12;
    localparam logic [7:0] OP_LLDI  = 8'd14;
    localparam logic [7:0] OP_LFORK = 8'd15;

    localparam logic [3:0] POS_NO_CODING = 4'd1;
    localparam logic [3:0] POS_CODING    = 4'd2;

    typedef struct packed {
        logic [63:0] window_head;
        logic [47:0] window_tail;
    } t_vmid_in;

    typedef struct packed {
        logic [7:0]  opcode;
        logic        opcode_ok;
        logic [1:0]  kind_a;
        logic [1:0]  kind_b;
        logic [1:0]  kind_c;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic [31:0] operand_c;
        logic [3:0]  length_bytes;
    } t_vmid_out;

    function automatic logic [2:0] kind_size(input logic [1:0] kind, input logic short_dir);
        logic [2:0] size;
        case (kind)
            KIND_REG: size = 3'd1;
            KIND_DIR: size = short_dir ? 3'd2 : 3'd4;
            KIND_IND: size = 3'd2;
            default:  size = 3'd0;
        endcase
        return size;
    endfunction

endpackage

`default_nettype wire

### rtl/vmid_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface vmid_in_if;
    import vmid_pkg::*;

    logic     valid;
    logic     ready;
    t_vmid_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/vmid_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface vmid_out_if;
    import vmid_pkg::*;

    logic      valid;
    logic      ready;
    t_vmid_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/vm_instruction_decoder_core.sv
// vm_instruction_decoder_core
// decodes one virtual machine instruction from a 14-byte window per transaction
// input channel i_in: window_head holds bytes 0..7 (byte 0 on top),
//   window_tail holds bytes 8..13; a transaction moves on valid and ready high
// output channel o_out: opcode, opcode_ok, three parameter kinds and values,
//   and the total instruction length in bytes
// three register stages: opcode and coding byte decode with operand offsets,
//   byte selection by offset, then alignment by size into the output register
// throughput: one transaction per cycle while o_out.ready stays high, set by the three-stage pipeline
// each stage advances when it is empty or the stage after it advances, so a
//   stalled receiver fills the pipeline and then drops i_in.ready; bubbles
//   are squeezed out and no transaction is lost or repeated
// reset (synchronous, active low) empties all stages; the block holds no
//   other state between transactions
`timescale 1ns / 1ps
`default_nettype none

module vm_instruction_decoder_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    vmid_in_if.sink    i_in,
    vmid_out_if.source o_out
);
    import vmid_pkg::*;

    logic w_rdy1;
    logic w_rdy2;
    logic w_rdy3;

    // stage 1
    logic                              r_v1;
    logic [WIN_BITS-1:0]               r_win1;
    logic [7:0]                        r_op1;
    logic                              r_ok1;
    logic [NUM_PARAMS-1:0][1:0]        r_kind1;
    logic [NUM_PARAMS-1:0][3:0]        r_pos1;
    logic [NUM_PARAMS-1:0][2:0]        r_size1;
    logic [3:0]                        r_len1;
    logic [WIN_BITS-1:0]               n_win1;
    logic                              n_ok1;
    logic [NUM_PARAMS-1:0][1:0]        n_kind1;
    logic [NUM_PARAMS-1:0][3:0]        n_pos1;
    logic [NUM_PARAMS-1:0][2:0]        n_size1;
    logic [3:0]                        n_len1;

    // stage 2
    logic                              r_v2;
    logic [7:0]                        r_op2;
    logic                              r_ok2;
    logic [NUM_PARAMS-1:0][1:0]        r_kind2;
    logic [NUM_PARAMS-1:0][2:0]        r_size2;
    logic [NUM_PARAMS-1:0][31:0]       r_raw2;
    logic [3:0]                        r_len2;
    logic [NUM_PARAMS-1:0][31:0]       n_raw2;

    // stage 3
    logic                              r_v3;
    t_vmid_out                         r_out;
    t_vmid_out                         n_out;

    assign w_rdy3 = !r_v3 || o_out.ready;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign i_in.ready  = w_rdy1;
    assign o_out.valid = r_v3;
    assign o_out.data  = r_out;

    // opcode and coding byte decode
    always_comb begin
        logic [7:0] op;
        logic [7:0] cb;
        logic       no_cb;
        logic       short_dir;
        op        = i_in.data.window_head[63:56];
        cb        = i_in.data.window_head[55:48];
        n_win1    = {i_in.data.window_head, i_in.data.window_tail};
        n_ok1     = (op >= OP_MIN) && (op <= OP_MAX);
        no_cb     = (op == OP_LIVE) || (op == OP_ZJMP) || (op == OP_FORK) || (op == OP_LFORK);
        short_dir = (op == OP_ZJMP) || (op == OP_LDI) || (op == OP_STI) || (op == OP_FORK)
                    || (op == OP_LLDI) || (op == OP_LFORK);
        if (!n_ok1) begin
            n_kind1 = '{KIND_NONE, KIND_NONE, KIND_NONE};
        end else if (no_cb) begin
            n_kind1 = '{KIND_NONE, KIND_NONE, KIND_DIR};
        end else begin
            n_kind1 = '{cb[3:2], cb[5:4], cb[7:6]};
        end
        for (int k = 0; k < NUM_PARAMS; k++) begin
            n_size1[k] = kind_size(n_kind1[k], short_dir);
        end
        n_pos1[0] = (n_ok1 && !no_cb) ? POS_CODING : POS_NO_CODING;
        n_pos1[1] = n_pos1[0] + {1'b0, n_size1[0]};
        n_pos1[2] = n_pos1[1] + {1'b0, n_size1[1]};
        n_len1    = n_pos1[2] + {1'b0, n_size1[2]};
    end

    // byte selection at each operand offset
    always_comb begin
        logic [WIN_BITS-1:0] sh;
        for (int k = 0; k < NUM_PARAMS; k++) begin
            sh        = r_win1 << {r_pos1[k], 3'b000};
            n_raw2[k] = sh[WIN_BITS-1 -: 32];
        end
    end

    // alignment by operand size
    always_comb begin
        logic [NUM_PARAMS-1:0][31:0] val;
        for (int k = 0; k < NUM_PARAMS; k++) begin
            case (r_size2[k])
                3'd1:    val[k] = {24'd0, r_raw2[k][31:24]};
                3'd2:    val[k] = {16'd0, r_raw2[k][31:16]};
                3'd4:    val[k] = r_raw2[k];
                default: val[k] = 32'd0;
            endcase
        end
        n_out.opcode       = r_op2;
        n_out.opcode_ok    = r_ok2;
        n_out.kind_a       = r_kind2[0];
        n_out.kind_b       = r_kind2[1];
        n_out.kind_c       = r_kind2[2];
        n_out.operand_a    = val[0];
        n_out.operand_b    = val[1];
        n_out.operand_c    = val[2];
        n_out.length_bytes = r_len2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_in.valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_win1  <= n_win1;
            r_op1   <= i_in.data.window_head[63:56];
            r_ok1   <= n_ok1;
            r_kind1 <= n_kind1;
            r_pos1  <= n_pos1;
            r_size1 <= n_size1;
            r_len1  <= n_len1;
        end
        if (w_rdy2) begin
            r_op2   <= r_op1;
            r_ok2   <= r_ok1;
            r_kind2 <= r_kind1;
            r_size2 <= r_size1;
            r_raw2  <= n_raw2;
            r_len2  <= r_len1;
        end
        if (w_rdy3) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_accept_fills_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_v1)
        else $error("accepted transaction did not reach stage 1");

    a_invalid_op_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !r_out.opcode_ok |-> r_out.length_bytes == 4'd1 && r_out.kind_a == KIND_NONE
            && r_out.kind_b == KIND_NONE && r_out.kind_c == KIND_NONE)
        else $error("invalid opcode with parameters or length other than one");

    a_valid_op_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r_out.opcode_ok |-> r_out.length_bytes >= 4'd2 && r_out.length_bytes <= 4'd14)
        else $error("valid opcode with length out of range");

    a_stall_holds_stage3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !o_out.ready |=> r_v3 && $stable(r_out))
        else $error("output register changed while stalled");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_v2 && r_v3 && !o_out.ready |-> !i_in.ready)
        else $error("input taken while the pipeline is full and stalled");
`endif

endmodule

`default_nettype wire

### tb/vmid_decode_checker.sv
`timescale 1ns / 1ps

module vmid_decode_checker (
    input  wire  i_clk,
    input  wire  i_rst_n,
    vmid_in_if   i_in_mon,
    vmid_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_outstanding,
    output int   o_checked
);
    import vmid_pkg::*;

    t_vmid_out expected_decodes[$];

    function automatic t_vmid_out decode_window(input t_vmid_in w);
        logic [111:0] win_bytes;
        logic [7:0]   op;
        logic [7:0]   coding;
        logic [1:0]   kinds [3];
        logic [31:0]  vals [3];
        logic         short_dir;
        int           nbytes;
        int           pos;
        t_vmid_out    r;
        win_bytes = {w.window_head, w.window_tail};
        op = win_bytes[111 -: 8];
        r = '0;
        r.opcode = op;
        r.length_bytes = 4'd1;
        if (op < OP_MIN || op > OP_MAX) begin
            return r;
        end
        for (int k = 0; k < 3; k++) begin
            kinds[k] = KIND_NONE;
            vals[k] = '0;
        end
        if (op == OP_LIVE || op == OP_ZJMP || op == OP_FORK || op == OP_LFORK) begin
            kinds[0] = KIND_DIR;
            pos = 1;
        end else begin
            coding = win_bytes[103 -: 8];
            kinds[0] = coding[7:6];
            kinds[1] = coding[5:4];
            kinds[2] = coding[3:2];
            pos = 2;
        end
        short_dir = (op >= OP_ZJMP && op <= OP_FORK) || op == OP_LLDI || op == OP_LFORK;
        for (int k = 0; k < 3; k++) begin
            case (kinds[k])
                KIND_REG: nbytes = 1;
                KIND_DIR: nbytes = short_dir ? 2 : 4;
                KIND_IND: nbytes = 2;
                default:  nbytes = 0;
            endcase
            for (int i = 0; i < nbytes; i++) begin
                vals[k] = {vals[k][23:0], win_bytes[111 - 8 * pos -: 8]};
                pos++;
            end
        end
        r.opcode_ok = 1'b1;
        r.kind_a = kinds[0];
        r.kind_b = kinds[1];
        r.kind_c = kinds[2];
        r.operand_a = vals[0];
        r.operand_b = vals[1];
        r.operand_c = vals[2];
        r.length_bytes = 4'(pos);
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_vmid_out want;
        t_vmid_out got;
        if (!i_rst_n) begin
            expected_decodes.delete();
            o_fail_count = 0;
            o_outstanding = 0;
            o_checked = 0;
        end else begin
            // results first: a window cannot come out on the edge it goes in
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = i_out_mon.data;
                if (expected_decodes.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("unexpected result transaction: opcode=%h", got.opcode);
                    end
                end else begin
                    want = expected_decodes.pop_front();
                    o_checked++;
                    if (got.opcode !== want.opcode || got.opcode_ok !== want.opcode_ok ||
                        got.kind_a !== want.kind_a || got.kind_b !== want.kind_b ||
                        got.kind_c !== want.kind_c || got.operand_a !== want.operand_a ||
                        got.operand_b !== want.operand_b || got.operand_c !== want.operand_c ||
                        got.length_bytes !== want.length_bytes) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display(
                                "#%0d expected op=%h ok=%b k=%0d/%0d/%0d v=%h/%h/%h len=%0d",
                                o_fail_count, want.opcode, want.opcode_ok, want.kind_a,
                                want.kind_b, want.kind_c, want.operand_a, want.operand_b,
                                want.operand_c, want.length_bytes);
                            $display(
                                "#%0d actual   op=%h ok=%b k=%0d/%0d/%0d v=%h/%h/%h len=%0d",
                                o_fail_count, got.opcode, got.opcode_ok, got.kind_a,
                                got.kind_b, got.kind_c, got.operand_a, got.operand_b,
                                got.operand_c, got.length_bytes);
                        end
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                expected_decodes.push_back(decode_window(i_in_mon.data));
            end
            o_outstanding = expected_decodes.size();
        end
    end

endmodule

### tb/vm_instruction_decoder_core_test.sv
`timescale 1ns / 1ps

module vm_instruction_decoder_core_test;
    import vmid_pkg::*;

    localparam int TOTAL_WINDOWS = 1850;

    logic clk = 1'b0;
    logic rst_n;

    int fail_count;
    int outstanding;
    int checked;
    int sent = 0;
    int legal_ops = 0;

    vmid_in_if  win_ch ();
    vmid_out_if dec_ch ();

    vm_instruction_decoder_core uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (win_ch),
        .o_out   (dec_ch)
    );

    vmid_decode_checker chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_mon      (win_ch),
        .i_out_mon     (dec_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results still awaited", outstanding);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic t_vmid_in random_window();
        t_vmid_in w;
        logic [7:0] op;
        w.window_head = {$urandom, $urandom};
        w.window_tail = {16'($urandom), $urandom};
        case ($urandom_range(0, 9))
            0:       op = 8'($urandom);
            1:       op = 8'($urandom_range(17, 127));
            default: op = 8'($urandom_range(OP_MIN, OP_MAX));
        endcase
        w.window_head[63:56] = op;
        return w;
    endfunction

    function automatic t_vmid_in shaped_window(input logic [7:0] op, input logic [7:0] coding);
        t_vmid_in w;
        w = random_window();
        w.window_head[63:48] = {op, coding};
        return w;
    endfunction

    // stretches of back-to-back traffic between randomly idling ones
    function automatic int draw_gap(input int idx, input int span);
        if ((idx / span) % 3 == 1) begin
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    task automatic send_window(input t_vmid_in w);
        int gap;
        gap = draw_gap(sent, 150);
        if (gap > 0) begin
            win_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        win_ch.valid <= 1'b1;
        win_ch.data  <= w;
        do @(posedge clk); while (win_ch.ready !== 1'b1);
        sent++;
        if (w.window_head[63:56] >= OP_MIN && w.window_head[63:56] <= OP_MAX) begin
            legal_ops++;
        end
    endtask

    task automatic drain_pause();
        win_ch.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
    endtask

    // receiver
    initial begin : result_sink
        int stall;
        int taken;
        taken = 0;
        dec_ch.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            stall = draw_gap(taken, 200);
            // long hold-off so the pipeline fills and backs up the input
            if (taken == 400 || taken == 1300) begin
                stall = 120;
            end
            if (stall > 0) begin
                dec_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            dec_ch.ready <= 1'b1;
            do @(posedge clk); while (dec_ch.valid !== 1'b1);
            taken++;
        end
    end

    // sender
    initial begin : window_source
        t_vmid_in w;
        win_ch.valid <= 1'b0;
        win_ch.data  <= '0;
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // illegal opcodes, including the bytes that read as negative
        send_window('0);
        send_window('1);
        send_window(shaped_window(8'h80, 8'hFF));
        send_window(shaped_window(8'h7F, 8'hFF));
        send_window(shaped_window(OP_MAX + 8'd1, 8'hFF));
        for (int op = OP_MIN; op <= OP_MAX; op++) begin
            send_window(shaped_window(8'(op), 8'($urandom)));
        end
        // longest instruction, coding byte low bits set
        w = '1;
        w.window_head[63:48] = {OP_MAX, KIND_DIR, KIND_DIR, KIND_DIR, 2'b11};
        send_window(w);
        send_window(shaped_window(OP_LDI, {KIND_DIR, KIND_DIR, KIND_DIR, 2'b00}));
        send_window(shaped_window(OP_LLDI, {KIND_REG, KIND_REG, KIND_REG, 2'b00}));
        send_window(shaped_window(OP_MAX, {KIND_NONE, KIND_NONE, KIND_IND, 2'b01}));
        drain_pause();

        while (sent < TOTAL_WINDOWS) begin
            send_window(random_window());
            if (sent == 900) begin
                drain_pause();
            end
        end
        win_ch.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (10) @(posedge clk);

        $display("%0d instruction windows decoded (%0d with a legal opcode), %0d results compared",
                 sent, legal_ops, checked);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatching transactions", fail_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
